[rtl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the checked integer ALU
// Opcodes and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int MODE_W  = 3;
  localparam int FIELD_W = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_NEG = 3'd3,
    MODE_ABS = 3'd4,
    MODE_DIV = 3'd5,
    MODE_MOD = 3'd6,
    MODE_PWR = 3'd7
  } mode_t;

endpackage

[rtl/cia_if.sv]
// ----------------------------------------------------------------------------
// cia_if: valid/ready channels of the checked integer ALU
// Operation channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface cia_in_if import cia_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [FIELD_W-1:0] operand_a;
  logic signed [FIELD_W-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface cia_out_if import cia_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] result_value;
  logic                      no_result;

  modport source (output valid, result_value, no_result, input ready);
  modport sink   (input valid, result_value, no_result, output ready);
endinterface

[rtl/checked_integer_alu.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu: signed ALU with overflow and divide checks
// Add, subtract, multiply, negate, abs, floor divide, floor modulo and power
// over WIDTH-bit two's complement; flags results that cannot be represented.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake     | payload
//  ----------+-----------+---------------+----------------------------------
//  in_chan   | sink      | valid / ready | mode, operand_a, operand_b
//  out_chan  | source    | valid / ready | result_value, no_result
//
//  Add, sub, negate and abs are computed at accept into the result register
//  and pass through S_FIN to the output register. Multiply, divide and modulo
//  use the bit-serial shift-add multiplier and restoring divider, which
//  retire one bit per cycle. Power runs up to 2*WIDTH-3 multiplies on that
//  one multiplier.
//  One transaction is in work at a time; the output register lets the next
//  transaction enter while a result waits for out_chan.ready.
//  Reset (rst_n low, synchronous) returns to idle and drops any result.
//
module checked_integer_alu import cia_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cia_in_if.sink    in_chan,
  cia_out_if.source out_chan
);

  localparam int W  = WIDTH;
  localparam int CW = $clog2(WIDTH);

  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_W = ~MIN_W;
  localparam logic [W-1:0] ONE_W = W'(1);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_MEND = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_DEND = 7'b0010000,
    S_PWR  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [W-1:0]      opb_r, opb_nxt;
  logic [W-1:0]      res_r, res_nxt;
  logic              fail_r, fail_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  // multiplier
  logic [W-1:0] mul_x_r, mul_x_nxt;
  logic [W-1:0] mul_hi_r, mul_hi_nxt;
  logic [W-1:0] mul_lo_r, mul_lo_nxt;
  logic         mul_neg_r, mul_neg_nxt;

  // power sequencer
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] base_r, base_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic         pw_sq_r, pw_sq_nxt;

  // divider
  logic [W-1:0] dv_d_r, dv_d_nxt;
  logic [W-1:0] dv_q_r, dv_q_nxt;
  logic [W-1:0] dv_rm_r, dv_rm_nxt;
  logic         dv_sa_r, dv_sa_nxt;
  logic         dv_sb_r, dv_sb_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_value_r, out_value_nxt;
  logic              out_fail_r, out_fail_nxt;

  logic [W-1:0] a_w, b_w;
  logic         in_fire;

  // multiplier start request
  logic         mul_go;
  logic [W-1:0] mul_p, mul_q;

  // datapath temporaries
  logic [W-1:0] sum_w, shift_exp;
  logic [W:0]   mul_sum, dv_rs, dv_diff;
  logic         mul_ovf;
  logic [W-1:0] mul_val, mul_lim, qt, rt;
  logic         dv_adj;

  assign a_w     = in_chan.operand_a[W-1:0];
  assign b_w     = in_chan.operand_b[W-1:0];
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.no_result    = out_fail_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    opb_nxt       = opb_r;
    res_nxt       = res_r;
    fail_nxt      = fail_r;
    cnt_nxt       = cnt_r;
    mul_x_nxt     = mul_x_r;
    mul_hi_nxt    = mul_hi_r;
    mul_lo_nxt    = mul_lo_r;
    mul_neg_nxt   = mul_neg_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    pw_sq_nxt     = pw_sq_r;
    dv_d_nxt      = dv_d_r;
    dv_q_nxt      = dv_q_r;
    dv_rm_nxt     = dv_rm_r;
    dv_sa_nxt     = dv_sa_r;
    dv_sb_nxt     = dv_sb_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_fail_nxt  = out_fail_r;
    mul_go        = 1'b0;
    mul_p         = acc_r;
    mul_q         = base_r;
    sum_w         = '0;
    shift_exp     = exp_r >> 1;
    mul_sum       = {1'b0, mul_hi_r} + (mul_lo_r[0] ? {1'b0, mul_x_r} : '0);
    dv_rs         = {dv_rm_r, dv_q_r[W-1]};
    dv_diff       = dv_rs - {1'b0, dv_d_r};
    mul_lim       = mul_neg_r ? MIN_W : MAX_W;
    mul_ovf       = (mul_hi_r != '0) || (mul_lo_r > mul_lim);
    mul_val       = mul_neg_r ? -mul_lo_r : mul_lo_r;
    qt            = (dv_sa_r ^ dv_sb_r) ? -dv_q_r : dv_q_r;
    rt            = dv_sa_r ? -dv_rm_r : dv_rm_r;
    dv_adj        = (dv_rm_r != '0) && (dv_sa_r ^ dv_sb_r);

    // drain the output register
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt = in_chan.mode;
          opb_nxt  = b_w;
          fail_nxt = 1'b0;
          state_nxt = S_FIN;
          case (in_chan.mode)
            MODE_ADD: begin
              sum_w    = a_w + b_w;
              res_nxt  = sum_w;
              fail_nxt = (a_w[W-1] == b_w[W-1]) && (sum_w[W-1] != a_w[W-1]);
            end
            MODE_SUB: begin
              sum_w    = a_w - b_w;
              res_nxt  = sum_w;
              fail_nxt = (a_w[W-1] != b_w[W-1]) && (sum_w[W-1] != a_w[W-1]);
            end
            MODE_MUL: begin
              mul_go = 1'b1;
              mul_p  = a_w;
              mul_q  = b_w;
            end
            MODE_NEG: begin
              res_nxt  = -a_w;
              fail_nxt = (a_w == MIN_W);
            end
            MODE_ABS: begin
              res_nxt  = mag(a_w);
              fail_nxt = (a_w == MIN_W);
            end
            MODE_DIV, MODE_MOD: begin
              if ((b_w == '0) || ((a_w == MIN_W) && (b_w == '1))) begin
                fail_nxt = 1'b1;
              end else begin
                dv_d_nxt  = mag(b_w);
                dv_q_nxt  = mag(a_w);
                dv_rm_nxt = '0;
                dv_sa_nxt = a_w[W-1];
                dv_sb_nxt = b_w[W-1];
                cnt_nxt   = CNT_LAST;
                state_nxt = S_DIV;
              end
            end
            default: begin
              acc_nxt  = ONE_W;
              base_nxt = a_w;
              exp_nxt  = b_w;
              res_nxt  = ONE_W;
              // exponent zero or negative: result is one
              if (!b_w[W-1] && (b_w != '0)) begin
                state_nxt = S_PWR;
              end
            end
          endcase
        end
      end

      S_MUL: begin
        mul_hi_nxt = mul_sum[W:1];
        mul_lo_nxt = {mul_sum[0], mul_lo_r[W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = S_MEND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      S_MEND: begin
        if (mode_r == MODE_MUL) begin
          res_nxt   = mul_val;
          fail_nxt  = mul_ovf;
          state_nxt = S_FIN;
        end else if (mul_ovf) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          if (pw_sq_r) begin
            base_nxt = mul_val;
          end else begin
            acc_nxt = mul_val;
          end
          state_nxt = S_PWR;
        end
      end

      S_PWR: begin
        if (exp_r[0]) begin
          // multiply into the accumulator, then clear the bit just used
          mul_go    = 1'b1;
          mul_p     = acc_r;
          mul_q     = base_r;
          pw_sq_nxt = 1'b0;
          exp_nxt   = {exp_r[W-1:1], 1'b0};
        end else begin
          exp_nxt = shift_exp;
          if (shift_exp != '0) begin
            // square only while exponent bits remain
            mul_go    = 1'b1;
            mul_p     = base_r;
            mul_q     = base_r;
            pw_sq_nxt = 1'b1;
          end else begin
            res_nxt   = acc_r;
            state_nxt = S_FIN;
          end
        end
      end

      S_DIV: begin
        if (!dv_diff[W]) begin
          dv_rm_nxt = dv_diff[W-1:0];
        end else begin
          dv_rm_nxt = dv_rs[W-1:0];
        end
        dv_q_nxt = {dv_q_r[W-2:0], !dv_diff[W]};
        if (cnt_r == '0) begin
          state_nxt = S_DEND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      S_DEND: begin
        // floor rounding: a nonzero remainder of opposite sign lowers the quotient by one or adds the divisor
        if (mode_r == MODE_DIV) begin
          res_nxt = dv_adj ? qt - ONE_W : qt;
        end else begin
          res_nxt = dv_adj ? rt + opb_r : rt;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_fail_nxt  = fail_r;
          out_value_nxt = fail_r ? '0 : FIELD_W'(signed'(res_r));
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // launch the shared multiplier on magnitudes
    if (mul_go) begin
      mul_x_nxt   = mag(mul_p);
      mul_lo_nxt  = mag(mul_q);
      mul_hi_nxt  = '0;
      mul_neg_nxt = mul_p[W-1] ^ mul_q[W-1];
      cnt_nxt     = CNT_LAST;
      state_nxt   = S_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    opb_r       <= opb_nxt;
    res_r       <= res_nxt;
    fail_r      <= fail_nxt;
    mul_x_r     <= mul_x_nxt;
    mul_hi_r    <= mul_hi_nxt;
    mul_lo_r    <= mul_lo_nxt;
    mul_neg_r   <= mul_neg_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    pw_sq_r     <= pw_sq_nxt;
    dv_d_r      <= dv_d_nxt;
    dv_q_r      <= dv_q_nxt;
    dv_rm_r     <= dv_rm_nxt;
    dv_sa_r     <= dv_sa_nxt;
    dv_sb_r     <= dv_sb_nxt;
    out_value_r <= out_value_nxt;
    out_fail_r  <= out_fail_nxt;
  end

endmodule

[rtl/cia_checker.sv]
// ----------------------------------------------------------------------------
// cia_checker: port-level checks of the checked integer ALU
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker import cia_pkg::*; #(
  parameter int WIDTH = 64
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [FIELD_W-1:0] result_value,
  input logic                      no_result
);

  logic signed [FIELD_W-1:0] upper;
  assign upper = result_value >>> (WIDTH - 1);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(no_result))
    else $error("result changed while stalled");

  // one transaction in work: input closes after an accept
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input stayed open after accept");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_result |-> result_value == '0)
    else $error("flagged result is not zero");

  a_sext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (upper == '0) || (upper == '1))
    else $error("result not sign-extended from WIDTH");

endmodule

bind checked_integer_alu cia_checker #(.WIDTH(WIDTH)) u_cia_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .result_value (out_chan.result_value),
  .no_result    (out_chan.no_result)
);

[tb/alu_checker.sv]
// ----------------------------------------------------------------------------
// alu_checker: result predictor and scoreboard for the checked integer ALU
// Watches both channels, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module alu_checker import cia_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cia_in_if.sink    in_mon,
  cia_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending,
  output int        result_count
);

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic                      none;
  } alu_result_t;

  alu_result_t expected_results[$];

  localparam logic signed [WIDTH-1:0] MAX_W = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] MIN_W = {1'b1, {(WIDTH-1){1'b0}}};

  // Exact signed product, checked against the WIDTH-bit range.
  function automatic logic product_fits(input logic signed [WIDTH-1:0] x,
                                        input logic signed [WIDTH-1:0] y,
                                        output logic signed [WIDTH-1:0] p);
    logic signed [2*WIDTH-1:0] full;
    full = $signed(x) * $signed(y);
    p = full[WIDTH-1:0];
    return full == {{WIDTH{p[WIDTH-1]}}, p};
  endfunction

  function automatic alu_result_t predict_alu(input mode_t op,
                                              input logic [FIELD_W-1:0] ra,
                                              input logic [FIELD_W-1:0] rb);
    logic signed [WIDTH-1:0]   a, b, v, q, m, base, acc;
    logic signed [WIDTH:0]     wide;
    logic                      ok;
    alu_result_t               res;
    a = ra[WIDTH-1:0];
    b = rb[WIDTH-1:0];
    v = '0;
    ok = 1'b1;
    case (op)
      MODE_ADD: begin
        wide = $signed({a[WIDTH-1], a}) + $signed({b[WIDTH-1], b});
        v = wide[WIDTH-1:0];
        ok = wide[WIDTH] == wide[WIDTH-1];
      end
      MODE_SUB: begin
        wide = $signed({a[WIDTH-1], a}) - $signed({b[WIDTH-1], b});
        v = wide[WIDTH-1:0];
        ok = wide[WIDTH] == wide[WIDTH-1];
      end
      MODE_MUL: ok = product_fits(a, b, v);
      MODE_NEG: begin
        ok = a != MIN_W;
        v = -a;
      end
      MODE_ABS: begin
        ok = a != MIN_W;
        v = a[WIDTH-1] ? -a : a;
      end
      MODE_DIV, MODE_MOD: begin
        ok = (b != 0) && !(a == MIN_W && b == -1);
        if (ok) begin
          // truncating division, then shift to floor semantics
          q = a / b;
          m = a % b;
          if (m != 0 && (m[WIDTH-1] != b[WIDTH-1])) begin
            q = q - 1;
            m = m + b;
          end
          v = (op == MODE_DIV) ? q : m;
        end
      end
      default: begin
        acc = 1;
        base = a;
        q = b;
        while (ok && q > 0) begin
          if (q[0]) ok = product_fits(acc, base, acc);
          q = q >>> 1;
          if (ok && q > 0) ok = product_fits(base, base, base);
        end
        v = acc;
      end
    endcase
    res.value = ok ? FIELD_W'(v) : '0;
    res.none  = !ok;
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst_n) begin
      expected_results.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_alu(mode_t'(in_mon.mode),
                                               in_mon.operand_a, in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d no_result=%0b", $realtime,
                   out_mon.result_value, out_mon.no_result);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.result_value !== exp_r.value || out_mon.no_result !== exp_r.none) begin
            $display("%0t: mismatch expected value=%0d no_result=%0b actual value=%0d no_result=%0b",
                     $realtime, exp_r.value, exp_r.none, out_mon.result_value,
                     out_mon.no_result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the checked integer ALU
// Drives directed corner operations and random operations with random gaps
// on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import cia_pkg::*;

  localparam int       WIDTH       = 64;
  localparam int       RANDOM_OPS  = 400;
  // power is the slowest operation; the limit also covers receiver stalls
  localparam longint   CYCLE_LIMIT = 64'd30_000_000;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG1  = '1;

  logic   clk;
  logic   rst_n;
  longint cycles;
  int     fail_count, pending, result_count;
  int     sent;
  bit     long_holdoff;

  cia_in_if  in_chan ();
  cia_out_if out_chan ();

  checked_integer_alu #(.WIDTH(WIDTH)) u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  alu_checker #(.WIDTH(WIDTH)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan.sink), .out_mon(out_chan.sink),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and end the run if it hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Send one transaction: hold valid until the block takes it at a rising edge.
  // Valid drops only during a gap, so back-to-back transactions keep it high.
  task automatic send_op(input mode_t op, input logic [63:0] a, input logic [63:0] b);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.mode      <= op;
    in_chan.operand_a <= a;
    in_chan.operand_b <= b;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    sent++;
  endtask

  // Pick an operand leaning toward interesting corners.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return MIN64 + $urandom_range(0, 2);
      1:       return MAX64 - $urandom_range(0, 2);
      2:       return 64'($signed($urandom_range(0, 6)) - 3);
      3:       return 64'($signed($urandom_range(0, 2000)) - 1000);
      4:       return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Keep most power exponents small so the run stays short.
  function automatic logic [63:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return pick_operand();
      1:       return 64'($urandom_range(0, 70));
      default: return 64'($urandom_range(0, 12));
    endcase
  endfunction

  // Receiver: random stalls per result, with no-stall stretches.
  initial begin
    int wait_cycles;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_holdoff) begin
        out_chan.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_holdoff = 1'b0;
      end
      wait_cycles = ((sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
        @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin
    mode_t op;
    in_chan.valid     = 1'b0;
    in_chan.mode      = MODE_ADD;
    in_chan.operand_a = '0;
    in_chan.operand_b = '0;
    rst_n        = 1'b0;
    sent         = 0;
    long_holdoff = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners: overflow, zero divisor, min over -1, floor signs, power.
    send_op(MODE_ADD, MAX64, 64'd1);
    send_op(MODE_ADD, MIN64, NEG1);
    send_op(MODE_SUB, MIN64, 64'd1);
    send_op(MODE_SUB, MAX64, NEG1);
    send_op(MODE_MUL, MIN64, NEG1);
    send_op(MODE_MUL, MIN64, 64'd1);
    send_op(MODE_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
    send_op(MODE_NEG, MIN64, 64'd5);
    send_op(MODE_NEG, MAX64, MAX64);
    send_op(MODE_ABS, MIN64, '0);
    send_op(MODE_ABS, NEG1, MIN64);
    send_op(MODE_DIV, 64'd7, '0);
    send_op(MODE_DIV, MIN64, NEG1);
    send_op(MODE_DIV, 64'($signed(-7)), 64'd2);
    send_op(MODE_DIV, 64'd7, 64'($signed(-2)));
    send_op(MODE_MOD, 64'($signed(-7)), 64'd2);
    send_op(MODE_MOD, 64'd7, 64'($signed(-2)));
    send_op(MODE_MOD, MIN64, NEG1);
    send_op(MODE_MOD, 64'd5, '0);
    send_op(MODE_PWR, 64'd3, '0);
    send_op(MODE_PWR, 64'd5, MIN64);
    send_op(MODE_PWR, 64'($signed(-2)), 64'd63);
    send_op(MODE_PWR, 64'd2, 64'd63);
    send_op(MODE_PWR, 64'h0000_0001_0000_0000, 64'd1);
    send_op(MODE_PWR, 64'd2, MAX64);
    in_chan.valid <= 1'b0;

    // Pause until every result has come back.
    wait (pending == 0);

    // Random operations; around the midpoint, hold off the receiver to fill the block.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 2) long_holdoff = 1'b1;
      op = mode_t'($urandom_range(0, 7));
      send_op(op, pick_operand(), (op == MODE_PWR) ? pick_exponent() : pick_operand());
    end
    in_chan.valid <= 1'b0;

    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d transactions and %0d results over all eight operations,",
             sent, result_count);
    $display("with overflow, zero divisor and floor rounding corners plus random stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[checked_integer_alu.f]
rtl/cia_pkg.sv
rtl/cia_if.sv
rtl/checked_integer_alu.sv
rtl/cia_checker.sv
tb/alu_checker.sv
tb/testbench.sv
